// ===== rtl/csmd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, opcode and mode codes, and a helper function for the command
// stream method decoder. No dependencies.
package csmd_pkg;

    localparam int WORD_W   = 32;
    localparam int CLASS_W  = 10;
    localparam int METHOD_W = 12;
    localparam int ADDR_W   = 17;
    localparam int COUNT_W  = 16;
    localparam int MODE_W   = 2;
    localparam int OP_W     = 4;
    localparam int BIT_W    = 4;

    localparam logic [CLASS_W-1:0] HOST_CLASS_ID = 10'h001;

    localparam logic [OP_W-1:0] OP_SETCLASS = 4'h0;
    localparam logic [OP_W-1:0] OP_INCR     = 4'h1;
    localparam logic [OP_W-1:0] OP_NONINCR  = 4'h2;
    localparam logic [OP_W-1:0] OP_MASK     = 4'h3;
    localparam logic [OP_W-1:0] OP_IMM      = 4'h4;

    localparam logic [MODE_W-1:0] MODE_HEADER  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INCR    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NONINCR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MASKED  = 2'd3;

    localparam logic STATUS_WRITE = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef struct packed {
        logic [CLASS_W-1:0]  current_class;
        logic [MODE_W-1:0]   mode;
        logic [METHOD_W-1:0] base_method;
        logic [COUNT_W-1:0]  offset_count;
        logic [COUNT_W-1:0]  words_left;
        logic [COUNT_W-1:0]  pending_mask;
    } dec_state_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        logic [ADDR_W-1:0]  method_addr;
        logic [WORD_W-1:0]  argument;
        logic               status;
    } method_write_t;

    // Priority encoder: index of the lowest set bit, zero for an empty mask.
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [COUNT_W-1:0] m);
        logic [BIT_W-1:0] idx;
        logic             found;
        idx   = '0;
        found = 1'b0;
        for (int i = 0; i < COUNT_W; i++) begin
            if (m[i] && !found) begin
                idx   = BIT_W'(i);
                found = 1'b1;
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/csmd_decode.sv =====
`timescale 1ns / 1ps
// Combinational decode of one command word against the current decoder state.
// Depends on csmd_pkg.
module csmd_decode (
    input  logic [csmd_pkg::WORD_W-1:0] word,
    input  logic                        gather_start,
    input  csmd_pkg::dec_state_t        cur_state,
    output csmd_pkg::dec_state_t        nxt_state,
    output csmd_pkg::method_write_t     result,
    output logic                        result_valid
);
    import csmd_pkg::*;

    dec_state_t         st;
    logic [OP_W-1:0]    op;
    logic [BIT_W-1:0]   bit_idx;
    logic [COUNT_W-1:0] mask_left;

    assign op        = word[31:28];
    assign bit_idx   = lowest_bit(st.pending_mask);
    assign mask_left = st.pending_mask & (st.pending_mask - COUNT_W'(1));

    always_comb begin
        // gather start: back to host class, drop any unfinished command
        st = cur_state;
        if (gather_start) begin
            st.current_class = HOST_CLASS_ID;
            st.mode          = MODE_HEADER;
        end

        nxt_state           = st;
        result_valid        = 1'b0;
        result.class_id     = st.current_class;
        result.method_addr  = '0;
        result.argument     = word;
        result.status       = STATUS_WRITE;

        case (st.mode)
            MODE_INCR: begin
                result_valid           = 1'b1;
                result.method_addr     = ADDR_W'(st.base_method) + ADDR_W'(st.offset_count);
                nxt_state.offset_count = st.offset_count + COUNT_W'(1);
                nxt_state.words_left   = st.words_left - COUNT_W'(1);
                if (st.words_left == COUNT_W'(1)) begin
                    nxt_state.mode = MODE_HEADER;
                end
            end
            MODE_NONINCR: begin
                result_valid         = 1'b1;
                result.method_addr   = ADDR_W'(st.base_method);
                nxt_state.words_left = st.words_left - COUNT_W'(1);
                if (st.words_left == COUNT_W'(1)) begin
                    nxt_state.mode = MODE_HEADER;
                end
            end
            MODE_MASKED: begin
                result_valid           = 1'b1;
                result.method_addr     = ADDR_W'(st.base_method) + ADDR_W'(bit_idx);
                nxt_state.pending_mask = mask_left;
                if (mask_left == '0) begin
                    nxt_state.mode = MODE_HEADER;
                end
            end
            default: begin
                // header word
                nxt_state.base_method  = word[27:16];
                nxt_state.offset_count = '0;
                nxt_state.words_left   = '0;
                nxt_state.pending_mask = '0;
                nxt_state.mode         = MODE_HEADER;
                case (op)
                    OP_SETCLASS: begin
                        nxt_state.current_class = word[15:6];
                        nxt_state.pending_mask  = COUNT_W'(word[5:0]);
                        if (word[5:0] != '0) begin
                            nxt_state.mode = MODE_MASKED;
                        end
                    end
                    OP_INCR: begin
                        nxt_state.words_left = word[15:0];
                        if (word[15:0] != '0) begin
                            nxt_state.mode = MODE_INCR;
                        end
                    end
                    OP_NONINCR: begin
                        nxt_state.words_left = word[15:0];
                        if (word[15:0] != '0) begin
                            nxt_state.mode = MODE_NONINCR;
                        end
                    end
                    OP_MASK: begin
                        nxt_state.pending_mask = word[15:0];
                        if (word[15:0] != '0) begin
                            nxt_state.mode = MODE_MASKED;
                        end
                    end
                    OP_IMM: begin
                        result_valid       = 1'b1;
                        result.method_addr = ADDR_W'(word[27:16]);
                        result.argument    = WORD_W'(word[11:0]);
                    end
                    default: begin
                        result_valid       = 1'b1;
                        result.method_addr = '0;
                        result.status      = STATUS_ERROR;
                    end
                endcase
            end
        endcase
    end

endmodule

// ===== rtl/command_stream_method_decoder_top.sv =====
`timescale 1ns / 1ps
// Top level of the command stream method decoder: input register, decode
// stage state and result register. Depends on csmd_pkg and csmd_decode.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_word[31:0], s_gather_start
//   m_        out        m_valid / m_ready  m_class_id[9:0], m_method_addr[16:0],
//                                           m_argument[31:0], m_status
//
// One command word per cycle is sustained while the result register is free or
// draining; a result passes the input register, then the result register,
// before it is valid and can be taken.
// The decode of one word is a single pass through csmd_decode: a 16-bit
// priority encoder and one 17-bit add set the path between the two registers.
// aresetn (synchronous, active low) empties both registers and sets the
// class to the host class with the decoder waiting for a header.
// A stalled result holds the decode stage; the input register still takes one
// transaction, so s_ready drops only when both stages are full.
module command_stream_method_decoder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [csmd_pkg::WORD_W-1:0]   s_word,
    input  logic                          s_gather_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [csmd_pkg::CLASS_W-1:0]  m_class_id,
    output logic [csmd_pkg::ADDR_W-1:0]   m_method_addr,
    output logic [csmd_pkg::WORD_W-1:0]   m_argument,
    output logic                          m_status
);
    import csmd_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_gather_reg;

    // decoder state
    dec_state_t state_reg;
    dec_state_t state_next;

    // result register
    logic          out_valid_reg;
    method_write_t out_reg;

    method_write_t dec_result;
    logic          dec_result_valid;
    logic          advance;

    // Advance the held word whenever the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    csmd_decode u_decode (
        .word         (in_word_reg),
        .gather_start (in_gather_reg),
        .cur_state    (state_reg),
        .nxt_state    (state_next),
        .result       (dec_result),
        .result_valid (dec_result_valid)
    );

    // Input register: load on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg   <= s_word;
            in_gather_reg <= s_gather_start;
        end
    end

    // Decoder state: advance once per decoded word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.current_class <= HOST_CLASS_ID;
            state_reg.mode          <= MODE_HEADER;
            state_reg.base_method   <= '0;
            state_reg.offset_count  <= '0;
            state_reg.words_left    <= '0;
            state_reg.pending_mask  <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register: fill on a producing word, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= dec_result_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && dec_result_valid) begin
            out_reg <= dec_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_class_id    = out_reg.class_id;
    assign m_method_addr = out_reg.method_addr;
    assign m_argument    = out_reg.argument;
    assign m_status      = out_reg.status;

    // A data mode always has work left.
    a_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == MODE_INCR || state_reg.mode == MODE_NONINCR)
        |-> (state_reg.words_left != '0))
        else $error("data mode with zero words left");

    a_mask_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == MODE_MASKED) |-> (state_reg.pending_mask != '0))
        else $error("masked mode with empty mask");

    a_error_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status == STATUS_ERROR) |-> (out_reg.method_addr == '0))
        else $error("error result with nonzero method address");

    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> $stable(state_reg))
        else $error("decoder state moved while result stalled");

endmodule
